FILE: hw/rtl/shb_pkg.sv
// ----------------------------------------------------------------------------
// shb_pkg
// Types, widths and constant tables for the spherical harmonic basis block.
// ----------------------------------------------------------------------------
package shb_pkg;

  localparam int CoordW = 16;
  localparam int SqW    = 32;
  localparam int CombW  = 35;
  localparam int PolyW  = 34;
  localparam int CoefW  = 27;
  localparam int ValW   = 18;

  typedef struct packed {
    logic       valid;
    logic [3:0] idx;
    logic       last;
  } shb_tag_t;

  function automatic logic signed [CoefW-1:0] shb_coef(input logic [3:0] idx);
    logic signed [CoefW-1:0] c;
    case (idx)
      4'd0:                c = 27'sd4732765;
      4'd1, 4'd2, 4'd3:    c = 27'sd8197390;
      4'd4, 4'd5, 4'd7:    c = 27'sd18329921;
      4'd6:                c = 27'sd5291392;
      4'd8:                c = 27'sd9164961;
      4'd9, 4'd15:         c = 27'sd9899289;
      4'd10:               c = 27'sd48496413;
      4'd11, 4'd13:        c = 27'sd7667956;
      4'd12:               c = 27'sd6260860;
      default:             c = 27'sd24248206;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] shb_band(input logic [3:0] idx);
    logic [1:0] b;
    case (idx)
      4'd0:                      b = 2'd0;
      4'd1, 4'd2, 4'd3:          b = 2'd1;
      4'd4, 4'd5, 4'd6, 4'd7, 4'd8: b = 2'd2;
      default:                   b = 2'd3;
    endcase
    return b;
  endfunction

  function automatic logic signed [2:0] shb_order(input logic [3:0] idx);
    logic signed [2:0] m;
    case (idx)
      4'd0, 4'd2, 4'd6, 4'd12: m = 3'sd0;
      4'd1, 4'd5, 4'd11:       m = -3'sd1;
      4'd3, 4'd7, 4'd13:       m = 3'sd1;
      4'd4, 4'd10:             m = -3'sd2;
      4'd8, 4'd14:             m = 3'sd2;
      4'd9:                    m = -3'sd3;
      default:                 m = 3'sd3;
    endcase
    return m;
  endfunction

  function automatic logic [3:0] shb_last_idx(input logic [1:0] band);
    logic [3:0] n;
    case (band)
      2'd0:    n = 4'd0;
      2'd1:    n = 4'd3;
      2'd2:    n = 4'd8;
      default: n = 4'd15;
    endcase
    return n;
  endfunction

endpackage

FILE: hw/rtl/shb_if.sv
// ----------------------------------------------------------------------------
// shb_if
// Valid/ready channels for directions, basis results and configuration.
// ----------------------------------------------------------------------------
interface shb_dir_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  modport source (output valid, dir_x, dir_y, dir_z, input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

interface shb_res_if;
  logic               valid;
  logic               ready;
  logic [3:0]         mode_index;
  logic [1:0]         band;
  logic signed [2:0]  order;
  logic signed [17:0] basis_value;
  logic               last_mode;
  modport source (output valid, mode_index, band, order, basis_value, last_mode,
                  input ready);
  modport sink   (input valid, mode_index, band, order, basis_value, last_mode,
                  output ready);
endinterface

interface shb_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] highest_band;
  modport source (output valid, highest_band, input ready);
  modport sink   (input valid, highest_band, output ready);
endinterface

FILE: hw/rtl/shb_seq.sv
// ----------------------------------------------------------------------------
// shb_seq
// Hold one direction and issue its mode indices, one per advancing cycle.
// ----------------------------------------------------------------------------
module shb_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic [1:0]          band_eff,
  shb_dir_if.sink             dir_in,
  output shb_pkg::shb_tag_t   tag,
  output logic signed [15:0]  x,
  output logic signed [15:0]  y,
  output logic signed [15:0]  z
);
  import shb_pkg::*;

  logic       busy;
  logic [3:0] idx;
  logic [3:0] last_idx;
  logic       at_last;
  logic       acc;

  assign at_last      = idx == last_idx;
  assign dir_in.ready = !busy || (adv && at_last);
  assign acc          = dir_in.valid && dir_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (acc) begin
      busy <= 1'b1;
    end else if (adv && busy && at_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      idx      <= 4'd0;
      last_idx <= shb_last_idx(band_eff);
      x        <= dir_in.dir_x;
      y        <= dir_in.dir_y;
      z        <= dir_in.dir_z;
    end else if (adv && busy && !at_last) begin
      idx <= idx + 4'd1;
    end
  end

  assign tag.valid = busy;
  assign tag.idx   = idx;
  assign tag.last  = at_last;

endmodule

FILE: hw/rtl/shb_poly.sv
// ----------------------------------------------------------------------------
// shb_poly
// Four-stage pipeline forming the Q30 Cartesian polynomial of one mode.
// ----------------------------------------------------------------------------
module shb_poly (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  shb_pkg::shb_tag_t       tag_in,
  input  logic signed [15:0]      x,
  input  logic signed [15:0]      y,
  input  logic signed [15:0]      z,
  output shb_pkg::shb_tag_t       tag_out,
  output logic signed [33:0]      poly
);
  import shb_pkg::*;

  shb_tag_t                t1, t2, t3;
  logic signed [SqW-1:0]   xx, yy, zz, xy, yz, zx;
  logic signed [CoordW-1:0] x1, y1, z1;

  logic signed [CombW-1:0] exx, eyy, ezz, exy, eyz, ezx;
  logic signed [CombW-1:0] comb;
  logic signed [CoordW-1:0] fac;
  logic signed [PolyW-1:0] plo;
  logic                    is3;

  logic signed [CombW-1:0]  comb2;
  logic signed [CoordW-1:0] fac2;
  logic signed [PolyW-1:0]  plo2;
  logic                     is3_2;

  logic signed [50:0]       prod3;
  logic signed [50:0]       rnd3;
  logic signed [PolyW-1:0]  plo3;
  logic                     is3_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.valid <= 1'b0;
      t2.valid <= 1'b0;
      t3.valid <= 1'b0;
      tag_out.valid <= 1'b0;
    end else if (adv) begin
      t1 <= tag_in;
      t2 <= t1;
      t3 <= t2;
      tag_out <= t3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xx <= x * x;
      yy <= y * y;
      zz <= z * z;
      xy <= x * y;
      yz <= y * z;
      zx <= z * x;
      x1 <= x;
      y1 <= y;
      z1 <= z;
    end
  end

  assign exx = CombW'(xx);
  assign eyy = CombW'(yy);
  assign ezz = CombW'(zz);
  assign exy = CombW'(xy);
  assign eyz = CombW'(yz);
  assign ezx = CombW'(zx);

  always_comb begin
    comb = exy;
    fac  = z1;
    plo  = '0;
    is3  = 1'b1;
    case (t1.idx)
      4'd0: begin
        is3 = 1'b0;
        plo = 34'sh40000000;
      end
      4'd1: begin
        is3 = 1'b0;
        plo = PolyW'(y1) <<< 15;
      end
      4'd2: begin
        is3 = 1'b0;
        plo = PolyW'(z1) <<< 15;
      end
      4'd3: begin
        is3 = 1'b0;
        plo = PolyW'(x1) <<< 15;
      end
      4'd4: begin
        is3 = 1'b0;
        plo = PolyW'(exy);
      end
      4'd5: begin
        is3 = 1'b0;
        plo = PolyW'(eyz);
      end
      4'd6: begin
        is3 = 1'b0;
        plo = PolyW'((ezz <<< 1) - exx - eyy);
      end
      4'd7: begin
        is3 = 1'b0;
        plo = PolyW'(ezx);
      end
      4'd8: begin
        is3 = 1'b0;
        plo = PolyW'(exx - eyy);
      end
      4'd9: begin
        comb = (exx <<< 1) + exx - eyy;
        fac  = y1;
      end
      4'd10: begin
        comb = exy;
        fac  = z1;
      end
      4'd11: begin
        comb = (ezz <<< 2) - exx - eyy;
        fac  = y1;
      end
      4'd12: begin
        comb = (ezz <<< 1) - (exx <<< 1) - exx - (eyy <<< 1) - eyy;
        fac  = z1;
      end
      4'd13: begin
        comb = (ezz <<< 2) - exx - eyy;
        fac  = x1;
      end
      4'd14: begin
        comb = exx - eyy;
        fac  = z1;
      end
      default: begin
        comb = exx - (eyy <<< 1) - eyy;
        fac  = x1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      comb2 <= comb;
      fac2  <= fac;
      plo2  <= plo;
      is3_2 <= is3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod3 <= 51'(comb2) * 51'(fac2);
      plo3  <= plo2;
      is3_3 <= is3_2;
    end
  end

  assign rnd3 = prod3 + 51'sd16384;

  always_ff @(posedge clk) begin
    if (adv) begin
      poly <= is3_3 ? PolyW'(rnd3 >>> 15) : plo3;
    end
  end

endmodule

FILE: hw/rtl/shb_scale.sv
// ----------------------------------------------------------------------------
// shb_scale
// Scale the polynomial by its constant, round to Q2.16, saturate and drive
// the result register.
// ----------------------------------------------------------------------------
module shb_scale (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  shb_pkg::shb_tag_t  tag_in,
  input  logic signed [33:0] poly,
  shb_res_if.source          res_out
);
  import shb_pkg::*;

  shb_tag_t           t5;
  logic signed [60:0] prod5;
  logic signed [60:0] rnd;
  logic signed [22:0] v;
  logic signed [ValW-1:0] sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      t5.valid      <= 1'b0;
      res_out.valid <= 1'b0;
    end else if (adv) begin
      t5            <= tag_in;
      res_out.valid <= t5.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod5   <= 61'(poly) * 61'(shb_coef(tag_in.idx));
    end
  end

  assign rnd = prod5 + (61'sd1 <<< 37);
  assign v   = 23'(rnd >>> 38);

  always_comb begin
    if (v > 23'sd131071) begin
      sat = 18'sd131071;
    end else if (v < -23'sd131072) begin
      sat = -18'sd131072;
    end else begin
      sat = ValW'(v);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_out.mode_index  <= t5.idx;
      res_out.band        <= shb_band(t5.idx);
      res_out.order       <= shb_order(t5.idx);
      res_out.basis_value <= sat;
      res_out.last_mode   <= t5.last;
    end
  end

endmodule

FILE: hw/rtl/spherical_harmonics_basis_eval_top.sv
// ----------------------------------------------------------------------------
// spherical_harmonics_basis_eval_top
// Real spherical harmonic basis, bands 0 to 3, one value per unstalled cycle.
//
//   channel   dir     word
//   dir_in    in      one direction, dir_x/dir_y/dir_z Q1.15
//   res_out   out     one basis value with mode index, band, order, last
//   cfg       in      highest_band
//
// A direction yields (band+1)^2 words, one per unstalled cycle, and holds the
// mode sequencer until its last word; the next is taken on the last.
// From the sequencer a mode passes the shb_poly stages, t5 and the result register.
// rst clears valid state and sets highest_band to 3.
// A stall on res_out freezes every stage; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module spherical_harmonics_basis_eval_top #(
  parameter int MAX_BAND = 3
) (
  input  logic       clk,
  input  logic       rst,
  shb_cfg_if.sink    cfg,
  shb_dir_if.sink    dir_in,
  shb_res_if.source  res_out
);
  import shb_pkg::*;

  logic [1:0]         highest_band;
  logic [1:0]         band_eff;
  logic               adv;
  shb_tag_t           tag0, tag4;
  logic signed [15:0] x, y, z;
  logic signed [33:0] poly;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      highest_band <= 2'd3;
    end else if (cfg.valid) begin
      highest_band <= cfg.highest_band;
    end
  end

  assign band_eff = (highest_band > 2'(MAX_BAND)) ? 2'(MAX_BAND) : highest_band;
  assign adv      = !res_out.valid || res_out.ready;

  shb_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .band_eff (band_eff),
    .dir_in   (dir_in),
    .tag      (tag0),
    .x        (x),
    .y        (y),
    .z        (z)
  );

  shb_poly u_poly (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .tag_in  (tag0),
    .x       (x),
    .y       (y),
    .z       (z),
    .tag_out (tag4),
    .poly    (poly)
  );

  shb_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .tag_in  (tag4),
    .poly    (poly),
    .res_out (res_out)
  );

`ifndef SYNTHESIS
  a_band_match: assert property (@(posedge clk) disable iff (rst)
    res_out.valid |-> res_out.band == shb_band(res_out.mode_index))
    else $error("band does not match mode index");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !res_out.valid)
    else $error("result valid straight after reset");

  a_modes_contiguous: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && res_out.ready && !res_out.last_mode |=>
      res_out.valid && res_out.mode_index == $past(res_out.mode_index) + 4'd1)
    else $error("gap in mode sequence");
`endif

endmodule

FILE: tb/spherical_harmonics_basis_eval_top_test.sv
// ----------------------------------------------------------------------------
// spherical_harmonics_basis_eval_top_test
// Self-checking bench for the spherical harmonic basis block. Directions go
// in through a queued driver with random idling. A monitor checks each basis
// word in order against values predicted at input acceptance. The bench runs
// through every highest-band setting, including a long hold-off on the result
// side and a quiet phase with no idling.
// ----------------------------------------------------------------------------
module spherical_harmonics_basis_eval_top_test;
  import shb_pkg::*;

  typedef struct {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } dir_t;

  typedef struct {
    logic [3:0]             mode_index;
    logic [1:0]             band;
    logic signed [2:0]      order;
    logic signed [ValW-1:0] basis_value;
    logic                   last_mode;
  } basis_word_t;

  logic clk;
  logic rst;
  logic quiet;
  logic hold_req;
  logic hold_done;
  int   hold_cnt;
  int   errors;
  logic [1:0] band_sel;

  dir_t        dir_pending[$];
  basis_word_t basis_expected[$];

  shb_cfg_if cfg();
  shb_dir_if dir_in();
  shb_res_if res_out();

  spherical_harmonics_basis_eval_top DUT (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .dir_in(dir_in),
    .res_out(res_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint rshift_round(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint to_q24(longint c_e11);
    return (c_e11 * 64'sd16777216 + 64'sd50000000000) / 64'sd100000000000;
  endfunction

  function automatic longint coef_of(int idx);
    case (idx)
      0:           return to_q24(64'sd28209479177);
      1, 2, 3:     return to_q24(64'sd48860251190);
      4, 5, 7:     return to_q24(64'sd109254843059);
      6:           return to_q24(64'sd31539156525);
      8:           return to_q24(64'sd54627421529);
      9, 15:       return to_q24(64'sd59004358992);
      10:          return to_q24(64'sd289061144264);
      11, 13:      return to_q24(64'sd45704579946);
      12:          return to_q24(64'sd37317633259);
      default:     return to_q24(64'sd144530572132);
    endcase
  endfunction

  function automatic longint poly_of(int idx, longint x, longint y, longint z);
    longint xx, yy, zz;
    xx = x * x;
    yy = y * y;
    zz = z * z;
    case (idx)
      0:  return longint'(1) <<< 30;
      1:  return y * 32768;
      2:  return z * 32768;
      3:  return x * 32768;
      4:  return x * y;
      5:  return y * z;
      6:  return 2 * zz - xx - yy;
      7:  return z * x;
      8:  return xx - yy;
      9:  return rshift_round((3 * xx - yy) * y, 15);
      10: return rshift_round(x * y * z, 15);
      11: return rshift_round(y * (4 * zz - xx - yy), 15);
      12: return rshift_round(z * (2 * zz - 3 * xx - 3 * yy), 15);
      13: return rshift_round(x * (4 * zz - xx - yy), 15);
      14: return rshift_round((xx - yy) * z, 15);
      default: return rshift_round((xx - 3 * yy) * x, 15);
    endcase
  endfunction

  task automatic predict_basis(dir_t d);
    basis_word_t w;
    longint v;
    int idx;
    for (int l = 0; l <= band_sel; l++) begin
      for (int m = -l; m <= l; m++) begin
        idx = l * l + l + m;
        v = rshift_round(poly_of(idx, d.x, d.y, d.z) * coef_of(idx), 38);
        if (v > 131071) v = 131071;
        if (v < -131072) v = -131072;
        w.mode_index  = idx[3:0];
        w.band        = l[1:0];
        w.order       = m[2:0];
        w.basis_value = v[ValW-1:0];
        w.last_mode   = (l == band_sel) && (m == l);
        basis_expected.push_back(w);
      end
    end
  endtask

  // drive directions
  always @(posedge clk) begin
    if (rst) begin
      dir_in.valid <= 1'b0;
    end else begin
      if (dir_in.valid && dir_in.ready) begin
        predict_basis('{dir_in.dir_x, dir_in.dir_y, dir_in.dir_z});
      end
      if (!dir_in.valid || dir_in.ready) begin
        if (dir_pending.size() != 0 && (quiet || $urandom_range(99) >= 27)) begin
          dir_t d;
          d = dir_pending.pop_front();
          dir_in.valid <= 1'b1;
          dir_in.dir_x <= d.x;
          dir_in.dir_y <= d.y;
          dir_in.dir_z <= d.z;
        end else begin
          dir_in.valid <= 1'b0;
        end
      end
    end
  end

  // count the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_cnt  <= 400;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // check basis words
  always @(posedge clk) begin
    if (rst) begin
      res_out.ready <= 1'b0;
    end else begin
      if (res_out.valid && res_out.ready) begin
        if (basis_expected.size() == 0) begin
          $error("unexpected word: mode_index %0d value %0d",
                 res_out.mode_index, res_out.basis_value);
          errors++;
        end else begin
          basis_word_t e;
          e = basis_expected.pop_front();
          if (res_out.mode_index !== e.mode_index) begin
            $error("mode_index: expected %0d, got %0d", e.mode_index, res_out.mode_index);
            errors++;
          end
          if (res_out.band !== e.band) begin
            $error("band: expected %0d, got %0d", e.band, res_out.band);
            errors++;
          end
          if (res_out.order !== e.order) begin
            $error("order: expected %0d, got %0d", e.order, res_out.order);
            errors++;
          end
          if (res_out.basis_value !== e.basis_value) begin
            $error("basis_value: expected %0d, got %0d", e.basis_value,
                   res_out.basis_value);
            errors++;
          end
          if (res_out.last_mode !== e.last_mode) begin
            $error("last_mode: expected %0d, got %0d", e.last_mode, res_out.last_mode);
            errors++;
          end
        end
      end
      res_out.ready <= (hold_cnt == 0) && (quiet || $urandom_range(99) >= 27);
    end
  end

  task automatic write_band(logic [1:0] b);
    cfg.valid        <= 1'b1;
    cfg.highest_band <= b;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    band_sel = b;
  endtask

  task automatic drain();
    while (dir_pending.size() != 0 || dir_in.valid || basis_expected.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic push_dir(int x, int y, int z);
    dir_t d;
    d.x = x[15:0];
    d.y = y[15:0];
    d.z = z[15:0];
    dir_pending.push_back(d);
  endtask

  task automatic push_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(1))
        push_dir($urandom, $urandom, $urandom);
      else
        push_dir(int'($urandom_range(46340)) - 23170, int'($urandom_range(46340)) - 23170,
                 int'($urandom_range(46340)) - 23170);
    end
  endtask

  initial begin
    rst              = 1'b1;
    quiet            = 1'b0;
    hold_req         = 1'b0;
    errors           = 0;
    band_sel         = 2'd3;
    cfg.valid        = 1'b0;
    cfg.highest_band = 2'd0;
    dir_in.valid     = 1'b0;
    dir_in.dir_x     = '0;
    dir_in.dir_y     = '0;
    dir_in.dir_z     = '0;
    res_out.ready    = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push_dir(0, 0, 0);
    push_dir(32767, 0, 0);
    push_dir(-32768, 0, 0);
    push_dir(0, 32767, 0);
    push_dir(0, -32768, 0);
    push_dir(0, 0, 32767);
    push_dir(0, 0, -32768);
    push_dir(32767, 32767, 32767);
    push_dir(-32768, -32768, -32768);
    push_dir(-32768, 32767, -32768);
    push_dir(32767, -32768, 32767);
    push_dir(23170, 23170, 0);
    push_dir(18919, 18919, 18919);
    push_dir(-18919, 18919, -18919);
    push_dir(1, 1, 1);
    push_dir(-1, -1, -1);
    drain();

    write_band(2'd0);
    push_random(30);
    drain();

    write_band(2'd1);
    quiet = 1'b1;
    push_random(30);
    drain();
    quiet = 1'b0;

    write_band(2'd3);
    push_random(30);
    hold_req = 1'b1;
    push_random(30);
    drain();

    write_band(2'd2);
    push_random(30);
    drain();

    write_band(2'd3);
    push_dir(-32768, -32768, 32767);
    push_random(20);
    drain();

    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: spherical_harmonics_basis_eval_top.f
hw/rtl/shb_pkg.sv
hw/rtl/shb_if.sv
hw/rtl/shb_seq.sv
hw/rtl/shb_poly.sv
hw/rtl/shb_scale.sv
hw/rtl/spherical_harmonics_basis_eval_top.sv
tb/spherical_harmonics_basis_eval_top_test.sv
